/* hdl/dnsqp_pkg.sv */
// ----------------------------------------------------------------------------
// dnsqp_pkg
// Shared types and constants for the question name parser: header length,
// result kinds, query type codes and the type class lookup.
// ----------------------------------------------------------------------------
package dnsqp_pkg;

  localparam int unsigned HEADER_BYTES = 12;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] qtype_t;
  typedef logic [2:0]  tclass_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam byte_t DOT_CHAR = 8'h2e;

  localparam qtype_t QT_A     = 16'd1;
  localparam qtype_t QT_AAAA  = 16'd28;
  localparam qtype_t QT_NS    = 16'd2;
  localparam qtype_t QT_CNAME = 16'd5;
  localparam qtype_t QT_MX    = 16'd15;

  localparam tclass_t TC_A     = 3'd0;
  localparam tclass_t TC_AAAA  = 3'd1;
  localparam tclass_t TC_NS    = 3'd2;
  localparam tclass_t TC_CNAME = 3'd3;
  localparam tclass_t TC_MX    = 3'd4;
  localparam tclass_t TC_OTHER = 3'd5;

  function automatic tclass_t classify_type(input qtype_t t);
    tclass_t c;
    unique case (t)
      QT_A:     c = TC_A;
      QT_AAAA:  c = TC_AAAA;
      QT_NS:    c = TC_NS;
      QT_CNAME: c = TC_CNAME;
      QT_MX:    c = TC_MX;
      default:  c = TC_OTHER;
    endcase
    return c;
  endfunction

endpackage

/* hdl/dns_question_name_parser_top.sv */
// ----------------------------------------------------------------------------
// dns_question_name_parser_top
// Parses the question name and query type out of a DNS message byte stream.
// ----------------------------------------------------------------------------
// Input channel pkt: one message byte per transfer, pkt_start high on the
// first byte of a message. The 12 header bytes are skipped, then the labels
// are walked and each name character goes out as a transfer on the res
// channel with item_kind 0, a dot ahead of every label after the first.
// After the zero length byte, the two type bytes give one transfer with
// item_kind 1 carrying query_type, type_class, name_length and
// name_overflow. Bytes after that are dropped until the next pkt_start.
// Names past MAX_NAME_CHARS characters are cut and flagged.
// A byte taken into the input register is parsed on its way into the
// result register, from which its result transfers. Throughput: one byte
// per cycle while no result is held by res_stall, set by the single parse
// step between the two registers.
// Reset: rst clears both registers' valid bits and returns the parser to
// idle; bytes before the first pkt_start give nothing.
// Stall: while res_stall holds a pending result, the input register holds
// too and pkt_stall rises once it is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module dns_question_name_parser_top #(
  parameter int unsigned MAX_NAME_CHARS = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pkt_valid,
  output logic                 pkt_stall,
  input  dnsqp_pkg::byte_t     pkt_byte,
  input  logic                 pkt_start,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic                 item_kind,
  output dnsqp_pkg::byte_t     name_char,
  output dnsqp_pkg::qtype_t    query_type,
  output dnsqp_pkg::tclass_t   type_class,
  output dnsqp_pkg::byte_t     name_length,
  output logic                 name_overflow
);
  import dnsqp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_NAME_CHARS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NAME_CHARS);
  localparam byte_t HDR_LAST = 8'(HEADER_BYTES - 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_LEN, PH_LABEL, PH_TYPE_HI, PH_TYPE_LO, PH_DONE
  } phase_t;

  // input register
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_start;

  // parser state
  phase_t           phase, phase_next;
  byte_t            countdown, countdown_next;
  logic [CNT_W-1:0] count, count_next;
  logic             first_label, first_label_next;
  logic             overflow, overflow_next;
  byte_t            type_hi, type_hi_next;

  logic   out_free, advance, produce, emit_want, emit_ok;
  logic   kind_next;
  byte_t  char_next;
  qtype_t qtype_w;

  assign out_free  = !res_valid || !res_stall;
  assign advance   = s1_valid && out_free;
  assign pkt_stall = s1_valid && !out_free;
  assign emit_ok   = count < MAX_CNT;
  assign qtype_w   = {type_hi, s1_byte};

  always_comb begin
    phase_next       = phase;
    countdown_next   = countdown;
    count_next       = count;
    first_label_next = first_label;
    overflow_next    = overflow;
    type_hi_next     = type_hi;
    emit_want        = 1'b0;
    produce          = 1'b0;
    kind_next        = KIND_CHAR;
    char_next        = s1_byte;
    if (s1_start) begin
      count_next       = '0;
      first_label_next = 1'b1;
      overflow_next    = 1'b0;
      type_hi_next     = '0;
      countdown_next   = HDR_LAST;
      phase_next       = (HDR_LAST == '0) ? PH_LEN : PH_HEADER;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          countdown_next = countdown - 8'd1;
          if (countdown_next == '0) phase_next = PH_LEN;
        end
        PH_LEN: begin
          if (s1_byte == '0) begin
            phase_next = PH_TYPE_HI;
          end else begin
            countdown_next = s1_byte;
            phase_next     = PH_LABEL;
            if (first_label) begin
              first_label_next = 1'b0;
            end else begin
              emit_want = 1'b1;
              char_next = DOT_CHAR;
            end
          end
        end
        PH_LABEL: begin
          countdown_next = countdown - 8'd1;
          if (countdown_next == '0) phase_next = PH_LEN;
          emit_want = 1'b1;
        end
        PH_TYPE_HI: begin
          type_hi_next = s1_byte;
          phase_next   = PH_TYPE_LO;
        end
        PH_TYPE_LO: begin
          phase_next = PH_DONE;
          produce    = 1'b1;
          kind_next  = KIND_DONE;
        end
        PH_IDLE, PH_DONE: begin
        end
        default: begin
        end
      endcase
      if (emit_want) begin
        if (emit_ok) begin
          count_next = count + 1'b1;
          produce    = 1'b1;
        end else begin
          overflow_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      res_valid   <= 1'b0;
      phase       <= PH_IDLE;
      countdown   <= '0;
      count       <= '0;
      first_label <= 1'b1;
      overflow    <= 1'b0;
      type_hi     <= '0;
    end else begin
      if (!pkt_stall) begin
        s1_valid <= pkt_valid;
        s1_byte  <= pkt_byte;
        s1_start <= pkt_start;
      end
      if (out_free) res_valid <= advance && produce;
      if (advance) begin
        phase       <= phase_next;
        countdown   <= countdown_next;
        count       <= count_next;
        first_label <= first_label_next;
        overflow    <= overflow_next;
        type_hi     <= type_hi_next;
        if (produce) begin
          item_kind <= kind_next;
          if (kind_next == KIND_DONE) begin
            name_char     <= '0;
            query_type    <= qtype_w;
            type_class    <= classify_type(qtype_w);
            name_length   <= (count > CNT_W'(255)) ? 8'd255 : 8'(count);
            name_overflow <= overflow;
          end else begin
            name_char     <= char_next;
            query_type    <= '0;
            type_class    <= TC_A;
            name_length   <= '0;
            name_overflow <= 1'b0;
          end
        end
      end
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("name count past limit");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    pkt_stall |-> s1_valid && res_valid && res_stall)
    else $error("input stalled without a blocked result");

  a_char_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && item_kind == KIND_CHAR |->
      query_type == '0 && name_length == '0 && !name_overflow)
    else $error("character result carries question fields");

  a_done_class: assert property (@(posedge clk) disable iff (rst)
    res_valid && item_kind == KIND_DONE |->
      type_class == classify_type(query_type) && name_char == '0)
    else $error("type class does not match query type");

  a_done_after_type: assert property (@(posedge clk) disable iff (rst)
    advance && !s1_start && phase == PH_TYPE_LO |=> res_valid && phase == PH_DONE)
    else $error("question completion not delivered");

endmodule

/* dv/dns_question_name_parser_top_test.sv */
// ----------------------------------------------------------------------------
// dns_question_name_parser_top_test
// Sends DNS messages byte by byte into the question name parser, works out
// the name characters and the question completion that each byte should
// give, and compares every result transfer field by field in order. Covers
// header skipping, dotted labels, empty and over-long names, literal
// compression pointers, restarts, trailing bytes and random traffic, under
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module dns_question_name_parser_top_test;
  import dnsqp_pkg::*;

  localparam int NAME_LIMIT = 255;
  localparam int ITEM_COUNT = 1950;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_LEN, PH_LABEL, PH_TYPE_HI, PH_TYPE_LO, PH_DONE
  } walk_phase_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_t;

  typedef struct {
    logic    kind;
    byte_t   ch;
    qtype_t  qt;
    tclass_t tc;
    byte_t   len;
    logic    ovf;
  } parse_result_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    pkt_valid = 1'b0;
  logic    pkt_stall;
  byte_t   pkt_byte = '0;
  logic    pkt_start = 1'b0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  logic    item_kind;
  byte_t   name_char;
  qtype_t  query_type;
  tclass_t type_class;
  byte_t   name_length;
  logic    name_overflow;

  dns_question_name_parser_top #(
    .MAX_NAME_CHARS(NAME_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt_byte(pkt_byte),
    .pkt_start(pkt_start),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .item_kind(item_kind),
    .name_char(name_char),
    .query_type(query_type),
    .type_class(type_class),
    .name_length(name_length),
    .name_overflow(name_overflow)
  );

  always #10 clk = ~clk;

  // parser state as seen by the testbench
  walk_phase_t walk_phase = PH_IDLE;
  byte_t       bytes_left = '0;
  int          chars_out = 0;
  logic        first_label = 1'b1;
  logic        name_cut = 1'b0;
  byte_t       type_hi = '0;

  parse_result_t pending_results[$];
  byte_t         msg_bytes[$];
  int            sent_count = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            burst_left = 0;
  stall_mode_t   stall_mode = STALL_NONE;
  int            mode_left = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic tclass_t type_class_of(input qtype_t t);
    tclass_t c;
    if (t == QT_A) c = TC_A;
    else if (t == QT_AAAA) c = TC_AAAA;
    else if (t == QT_NS) c = TC_NS;
    else if (t == QT_CNAME) c = TC_CNAME;
    else if (t == QT_MX) c = TC_MX;
    else c = TC_OTHER;
    return c;
  endfunction

  function automatic void push_name_char(input byte_t ch);
    parse_result_t r;
    if (chars_out >= NAME_LIMIT) begin
      name_cut = 1'b1;
    end else begin
      chars_out++;
      r.kind = KIND_CHAR;
      r.ch = ch;
      r.qt = '0;
      r.tc = '0;
      r.len = '0;
      r.ovf = 1'b0;
      pending_results.push_back(r);
    end
  endfunction

  // advances the expected parser by one accepted byte
  function automatic void walk_message_byte(input byte_t b, input logic s);
    parse_result_t r;
    if (s) begin
      chars_out = 0;
      first_label = 1'b1;
      name_cut = 1'b0;
      type_hi = '0;
      bytes_left = byte_t'(HEADER_BYTES - 1);
      walk_phase = (bytes_left == 0) ? PH_LEN : PH_HEADER;
    end else begin
      case (walk_phase)
        PH_HEADER: begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 0) walk_phase = PH_LEN;
        end
        PH_LEN: begin
          if (b == 0) begin
            walk_phase = PH_TYPE_HI;
          end else begin
            bytes_left = b;
            walk_phase = PH_LABEL;
            if (first_label) first_label = 1'b0;
            else push_name_char(DOT_CHAR);
          end
        end
        PH_LABEL: begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 0) walk_phase = PH_LEN;
          push_name_char(b);
        end
        PH_TYPE_HI: begin
          type_hi = b;
          walk_phase = PH_TYPE_LO;
        end
        PH_TYPE_LO: begin
          r.kind = KIND_DONE;
          r.ch = '0;
          r.qt = {type_hi, b};
          r.tc = type_class_of(r.qt);
          r.len = (chars_out > 255) ? 8'd255 : byte_t'(chars_out);
          r.ovf = name_cut;
          pending_results.push_back(r);
          walk_phase = PH_DONE;
        end
        default: ;
      endcase
    end
  endfunction

  task automatic send_byte(input byte_t b, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        pkt_valid <= 1'b0;
        pkt_byte <= byte_t'($urandom);
        pkt_start <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pkt_valid <= 1'b1;
    pkt_byte <= b;
    pkt_start <= s;
    @(posedge clk);
    while (pkt_stall) @(posedge clk);
    sent_count++;
    walk_message_byte(b, s);
  endtask

  function automatic void start_message(input int fill);
    msg_bytes.delete();
    for (int i = 0; i < HEADER_BYTES; i++)
      msg_bytes.push_back((fill < 0) ? byte_t'($urandom) : byte_t'(fill));
  endfunction

  function automatic void add_label(input int len);
    msg_bytes.push_back(byte_t'(len));
    for (int i = 0; i < len; i++) msg_bytes.push_back(byte_t'($urandom));
  endfunction

  function automatic void end_name(input qtype_t qt);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(qt[15:8]);
    msg_bytes.push_back(qt[7:0]);
  endfunction

  task automatic send_prefix(input int n);
    for (int i = 0; i < n; i++) send_byte(msg_bytes[i], i == 0);
  endtask

  task automatic send_message();
    send_prefix(msg_bytes.size());
  endtask

  function automatic qtype_t pick_qtype();
    qtype_t qt;
    case ($urandom_range(0, 7))
      0: qt = QT_A;
      1: qt = QT_AAAA;
      2: qt = QT_NS;
      3: qt = QT_CNAME;
      4: qt = QT_MX;
      5: qt = 16'hffff;
      6: qt = 16'h0000;
      default: qt = qtype_t'($urandom);
    endcase
    return qt;
  endfunction

  function automatic int pick_label_len(input bit long_name);
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (long_name) len = $urandom_range(20, 63);
    else if (r < 85) len = $urandom_range(1, 15);
    else if (r < 97) len = $urandom_range(16, 63);
    else len = $urandom_range(64, 255);
    return len;
  endfunction

  function automatic void build_random_message(input bit long_name);
    int n;
    int total;
    int limit;
    int len;
    start_message(-1);
    total = 0;
    limit = long_name ? $urandom_range(230, 320) : 0;
    n = long_name ? 0 : $urandom_range(0, 5);
    for (int i = 0; i < n || total < limit; i++) begin
      len = pick_label_len(long_name);
      add_label(len);
      total += len + 1;
    end
    end_name(pick_qtype());
    for (int i = $urandom_range(0, 3); i > 0; i--) msg_bytes.push_back(byte_t'($urandom));
  endfunction

  // bytes before the first start mark give nothing
  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
  endtask

  task automatic test_empty_name();
    start_message(0);
    end_name(QT_A);
    send_message();
  endtask

  task automatic test_type_codes();
    qtype_t codes[8];
    codes = '{QT_A, QT_AAAA, QT_NS, QT_CNAME, QT_MX, 16'h0000, 16'hffff, 16'h0100};
    foreach (codes[i]) begin
      start_message((i == 0) ? 255 : -1);
      add_label(1);
      end_name(codes[i]);
      send_message();
    end
  endtask

  task automatic test_dotted_labels();
    start_message(-1);
    add_label(1);
    add_label(63);
    add_label(2);
    end_name(QT_MX);
    send_message();
  endtask

  // length bytes of 0xc0 and up are plain label lengths
  task automatic test_pointer_length();
    start_message(-1);
    add_label(192);
    end_name(QT_CNAME);
    send_message();
  endtask

  // a full-size label reaches the limit; the next dot and label are cut
  task automatic test_long_name();
    start_message(-1);
    add_label(255);
    end_name(QT_A);
    send_message();
    start_message(-1);
    add_label(255);
    add_label(1);
    add_label(3);
    end_name(QT_AAAA);
    send_message();
  endtask

  task automatic test_restart();
    start_message(-1);
    add_label(5);
    end_name(QT_NS);
    send_prefix(5);
    send_prefix(15);
    send_prefix(HEADER_BYTES + 7);
    send_message();
  endtask

  task automatic test_trailing_bytes();
    start_message(-1);
    add_label(3);
    end_name(QT_A);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h05);
    msg_bytes.push_back(8'hff);
    send_message();
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
  endtask

  task automatic test_random_traffic();
    int sel;
    while (sent_count < ITEM_COUNT) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        for (int i = $urandom_range(1, 8); i > 0; i--) send_byte(byte_t'($urandom), 1'b0);
      end else begin
        build_random_message(sel < 9);
        if (sel < 20 && sel >= 9) send_prefix($urandom_range(1, msg_bytes.size() - 1));
        else send_message();
      end
    end
  endtask

  task automatic finish_run();
    pkt_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("dns_question_name_parser_top_test passed");
    end else begin
      $display("dns_question_name_parser_top_test failed");
    end
    $finish;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_empty_name();
    test_type_codes();
    test_dotted_labels();
    test_pointer_length();
    test_long_name();
    test_restart();
    test_trailing_bytes();
    test_random_traffic();
    finish_run();
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: res_stall <= 1'b0;
        STALL_HALF: res_stall <= 1'($urandom_range(0, 1));
        STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 8);
        default: res_stall <= cycle_count[2];
      endcase
    end
  end

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer kind %0b char %02h type %04h",
                                  item_kind, name_char, query_type));
      end else begin
        want = pending_results.pop_front();
        compare_field("item_kind", 16'(item_kind), 16'(want.kind));
        compare_field("name_char", 16'(name_char), 16'(want.ch));
        compare_field("query_type", query_type, want.qt);
        compare_field("type_class", 16'(type_class), 16'(want.tc));
        compare_field("name_length", 16'(name_length), 16'(want.len));
        compare_field("name_overflow", 16'(name_overflow), 16'(want.ovf));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dns_question_name_parser_top_test failed");
      $finish;
    end
  end

endmodule
